/* rtl/core/xed_pkg.sv */
// Package for the XML entity decoder: prefix state type, character codes,
// prefix text tables and the result bundle passed from step logic to top.
// No dependencies.
package xed_pkg;

  localparam int unsigned MaxResults = 6;
  localparam int unsigned MaxPrefix  = 5;

  localparam logic [7:0] CH_AMP   = 8'h26;  // &
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ;
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_QUOTE = 8'h22;  // "
  localparam logic [7:0] CH_APOS  = 8'h27;  // '
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // held prefix of a possible entity
  typedef enum logic [3:0] {
    MP_IDLE, MP_AMP1, MP_A, MP_AM, MP_AMP, MP_AP, MP_APO, MP_APOS,
    MP_L, MP_LT, MP_G, MP_GT, MP_Q, MP_QU, MP_QUO, MP_QUOT
  } mp_e;

  typedef logic [MaxPrefix-1:0][7:0] ptext_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;  // result bytes, first in entry 0
    logic [2:0]                 cnt;    // number of results, 0 to 6
  } res_t;

  function automatic logic [2:0] prefix_len(input mp_e s);
    logic [2:0] l;
    case (s)
      MP_IDLE:                         l = 3'd0;
      MP_AMP1:                         l = 3'd1;
      MP_A, MP_L, MP_G, MP_Q:          l = 3'd2;
      MP_AM, MP_AP, MP_LT, MP_GT, MP_QU: l = 3'd3;
      MP_AMP, MP_APO, MP_QUO:          l = 3'd4;
      MP_APOS, MP_QUOT:                l = 3'd5;
      default:                         l = 3'd0;
    endcase
    return l;
  endfunction

  // prefix text, first character in entry 0; unused entries are zero
  function automatic ptext_t prefix_text(input mp_e s);
    ptext_t t;
    t = '0;
    t[0] = CH_AMP;
    case (s)
      MP_IDLE: t[0] = 8'h00;
      MP_AMP1: ;
      MP_A:    t[1] = CH_A;
      MP_AM:   begin t[1] = CH_A; t[2] = CH_M; end
      MP_AMP:  begin t[1] = CH_A; t[2] = CH_M; t[3] = CH_P; end
      MP_AP:   begin t[1] = CH_A; t[2] = CH_P; end
      MP_APO:  begin t[1] = CH_A; t[2] = CH_P; t[3] = CH_O; end
      MP_APOS: begin t[1] = CH_A; t[2] = CH_P; t[3] = CH_O; t[4] = CH_S; end
      MP_L:    t[1] = CH_L;
      MP_LT:   begin t[1] = CH_L; t[2] = CH_T; end
      MP_G:    t[1] = CH_G;
      MP_GT:   begin t[1] = CH_G; t[2] = CH_T; end
      MP_Q:    t[1] = CH_Q;
      MP_QU:   begin t[1] = CH_Q; t[2] = CH_U; end
      MP_QUO:  begin t[1] = CH_Q; t[2] = CH_U; t[3] = CH_O; end
      MP_QUOT: begin t[1] = CH_Q; t[2] = CH_U; t[3] = CH_O; t[4] = CH_T; end
      default: t = '0;
    endcase
    return t;
  endfunction

  // decoded character when ';' follows the prefix, zero if none
  function automatic logic [7:0] done_char(input mp_e s);
    logic [7:0] d;
    case (s)
      MP_AMP:  d = CH_AMP;
      MP_APOS: d = CH_APOS;
      MP_LT:   d = CH_LT;
      MP_GT:   d = CH_GT;
      MP_QUOT: d = CH_QUOTE;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

  // prefix one character longer, MP_IDLE if the character breaks the match
  function automatic mp_e extend_state(input mp_e s, input logic [7:0] c);
    mp_e t;
    t = MP_IDLE;
    case (s)
      MP_AMP1: begin
        if (c == CH_A) t = MP_A;
        else if (c == CH_L) t = MP_L;
        else if (c == CH_G) t = MP_G;
        else if (c == CH_Q) t = MP_Q;
      end
      MP_A: begin
        if (c == CH_M) t = MP_AM;
        else if (c == CH_P) t = MP_AP;
      end
      MP_AM:  if (c == CH_P) t = MP_AMP;
      MP_AP:  if (c == CH_O) t = MP_APO;
      MP_APO: if (c == CH_S) t = MP_APOS;
      MP_L:   if (c == CH_T) t = MP_LT;
      MP_G:   if (c == CH_T) t = MP_GT;
      MP_Q:   if (c == CH_U) t = MP_QU;
      MP_QU:  if (c == CH_O) t = MP_QUO;
      MP_QUO: if (c == CH_T) t = MP_QUOT;
      default: t = MP_IDLE;
    endcase
    return t;
  endfunction

endpackage

/* rtl/core/xed_step.sv */
// Step logic of the XML entity decoder: next prefix state and the result
// bytes caused by one input byte. Depends on xed_pkg.
module xed_step
  import xed_pkg::*;
(
  input  mp_e        mp_i,
  input  logic [7:0] char_i,
  input  logic       eot_i,
  output mp_e        mp_next_o,
  output res_t       res_o
);

  logic       hit_done;
  logic       mism;
  logic       fresh;
  mp_e        ext;
  mp_e        mid;
  mp_e        seg_a;
  mp_e        seg_c;
  logic       has_b;
  logic [7:0] b_char;
  logic [2:0] len_a;
  logic [2:0] len_c;
  ptext_t     txt_a;
  ptext_t     txt_c;
  logic [2:0] total;

  // next state
  always_comb begin
    hit_done = (mp_i != MP_IDLE) && (char_i == CH_SEMI) && (done_char(mp_i) != 8'h00);
    ext      = extend_state(mp_i, char_i);
    mism     = (mp_i != MP_IDLE) && !hit_done && (ext == MP_IDLE);
    fresh    = (mp_i == MP_IDLE) || mism;
    if (hit_done) begin
      mid = MP_IDLE;
    end else if (!fresh) begin
      mid = ext;
    end else if (char_i == CH_AMP) begin
      mid = MP_AMP1;
    end else begin
      mid = MP_IDLE;
    end
    mp_next_o = eot_i ? MP_IDLE : mid;
  end

  // results: broken prefix, then one byte, then the flushed prefix
  // (at most six in total, so three bits hold the count)
  always_comb begin
    seg_a  = mism ? mp_i : MP_IDLE;
    seg_c  = eot_i ? mid : MP_IDLE;
    has_b  = hit_done || (fresh && (char_i != CH_AMP));
    b_char = hit_done ? done_char(mp_i) : char_i;
    len_a  = prefix_len(seg_a);
    len_c  = prefix_len(seg_c);
    txt_a  = prefix_text(seg_a);
    txt_c  = prefix_text(seg_c);
    total  = len_a + {2'b00, has_b} + len_c;
    res_o.cnt = total;
    for (int i = 0; i < MaxResults; i++) begin
      logic [2:0] pos;
      logic [2:0] j;
      pos = 3'(i);
      j   = pos - len_a - {2'b00, has_b};
      if (pos < len_a) begin
        res_o.bytes[i] = txt_a[pos];
      end else if (has_b && (pos == len_a)) begin
        res_o.bytes[i] = b_char;
      end else if (j < 3'(MaxPrefix)) begin
        res_o.bytes[i] = txt_c[j];
      end else begin
        res_o.bytes[i] = 8'h00;
      end
    end
  end

endmodule

/* rtl/core/xml_entity_decoder_top.sv */
// Top level of the XML entity decoder: stream ports, prefix state and
// result register with its read-out counter. Depends on xed_pkg, xed_step.
//
// Usage:
//   Feed escaped text on the slave stream one byte per item: tdata carries
//   the byte, tlast marks the final byte of a text and flushes any held
//   prefix. Decoded bytes leave on the master stream; tlast there marks the
//   last result caused by one input item. The five predefined entities
//   (amp, lt, gt, quot, apos) become their single characters; anything else
//   passes through unchanged, held bytes of a broken entity included.
// Latency and throughput:
//   An accepted item is decoded in the same cycle and its results are
//   registered, so the first result is offered in the cycle after acceptance.
//   An item giving n results (n from 1 to 6) holds the result register
//   until its last result is taken, one result per cycle while the receiver
//   is ready; an item giving none (a held entity prefix) leaves it empty.
//   Plain text thus runs at one byte per cycle while the receiver is ready;
//   the read-out counter over the result register paces multi-byte flushes.
// Reset:
//   rst_ni clears the prefix state and empties the result register.
// Stalls:
//   While the receiver holds m_axis_tready low the current result is held
//   and no new item is taken; the slave side is ready again in the cycle
//   the last result of the pending item is taken.
module xml_entity_decoder_top
  import xed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // slave stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // end_of_text
  // master stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // run_last
);

  mp_e                        mp_q, mp_d;
  logic [MaxResults-1:0][7:0] bytes_q;
  logic [2:0]                 cnt_q, cnt_d;
  logic [2:0]                 idx_q, idx_d;
  res_t                       res;
  logic                       busy;
  logic                       last_res;
  logic                       take_last;
  logic                       in_acc;

  xed_step u_step (
    .mp_i      (mp_q),
    .char_i    (s_axis_tdata),
    .eot_i     (s_axis_tlast),
    .mp_next_o (mp_d),
    .res_o     (res)
  );

  // result register is busy while it still holds results to offer
  assign busy      = (cnt_q != 3'd0);
  assign last_res  = (idx_q == (cnt_q - 3'd1));
  assign take_last = busy && m_axis_tready && last_res;
  assign s_axis_tready = !busy || take_last;
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = bytes_q[idx_q];
  assign m_axis_tlast  = last_res;

  // read-out counter: load on a new item, advance on each taken result
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (in_acc) begin
      cnt_d = res.cnt;
      idx_d = 3'd0;
    end else if (take_last) begin
      cnt_d = 3'd0;
      idx_d = 3'd0;
    end else if (busy && m_axis_tready) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q  <= MP_IDLE;
      cnt_q <= 3'd0;
      idx_q <= 3'd0;
    end else begin
      if (in_acc) begin
        mp_q <= mp_d;
      end
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // payload: hold the result bytes of the current item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bytes_q <= res.bytes;
    end
  end

endmodule
